// ----- rtl/iowt_pkg.sv -----
// Shared types, sizes and result codes for the I/O wait timer table.
package iowt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_ADDED = 2'd0;
    localparam logic [1:0] KIND_FULL  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Command transfer
    typedef struct packed {
        logic       operation;
        logic [7:0] process_id;
        logic [7:0] duration;
    } t_cmd;

    // Result transfer
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] done_id;
        logic       last;
    } t_result;

    // One table entry
    typedef struct packed {
        logic [7:0] id;
        logic [7:0] cycles;
    } t_entry;

    // Output of the shared countdown unit
    typedef struct packed {
        logic [7:0] cycles;
        logic       expired;
    } t_dec;

endpackage

// ----- rtl/iowt_table.sv -----
// Memory holding the ordered table entries: one write port and one registered read port.
module iowt_table (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [iowt_pkg::IDX_W-1:0] i_wr_idx,
    input  iowt_pkg::t_entry      i_wr_data,
    input  logic [iowt_pkg::IDX_W-1:0] i_rd_idx,
    output iowt_pkg::t_entry      o_rd_data
);
    import iowt_pkg::*;

    t_entry r_entries [TABLE_DEPTH];
    t_entry r_rd_data;

    // Write port; entries have no reset, only slots below the fill count are used
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entries[i_wr_idx] <= i_wr_data;
        end
    end

    // Read port, registered: data appears in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_entries[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/iowt_dec_unit.sv -----
// Shared countdown unit: saturating decrement and expiry compare.
module iowt_dec_unit (
    input  logic [7:0]    i_cycles,
    output iowt_pkg::t_dec o_dec
);
    import iowt_pkg::*;

    // Saturate at zero, expire once the count reaches zero
    always_comb begin
        o_dec.cycles  = (i_cycles == 8'd0) ? 8'd0 : i_cycles - 8'd1;
        o_dec.expired = (o_dec.cycles == 8'd0);
    end

endmodule

// ----- rtl/io_wait_timer_table_top.sv -----
// Top level of the I/O wait timer table: command decode, tick walk sequencer, result register.
//
//  channel   | ports                     | transfer when
//  ----------+---------------------------+-------------------------------
//  command   | start, busy, i_cmd        | start high and busy low
//  result    | o_strobe, o_result        | every cycle o_strobe is high
//
// An add's result appears the cycle after the transfer and busy stays low.
// A tick walks the table one entry per cycle through the shared countdown unit,
// then closes with the final result, busy high throughout. An empty-table tick
// answers without a walk and busy stays low. Reset is synchronous and clears the
// fill count, sequencer state and result strobe; table entries and payload registers
// are not reset. The receiver cannot stall; every result is shown for one cycle.
module io_wait_timer_table_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  iowt_pkg::t_cmd    i_cmd,
    output logic              o_strobe,
    output iowt_pkg::t_result o_result
);
    import iowt_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic             r_state,      n_state;
    logic [CNT_W-1:0] r_count,      n_count;
    logic [CNT_W-1:0] r_idx,        n_idx;
    logic [CNT_W-1:0] r_kept,       n_kept;
    logic             r_pend_valid, n_pend_valid;
    logic [7:0]       r_pend_id,    n_pend_id;
    logic             r_strobe,     n_strobe;
    t_result          r_result,     n_result;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    t_entry           wr_data;
    logic [IDX_W-1:0] rd_idx;
    t_entry           rd_data;
    t_dec             dec;
    logic             cmd_xfer;

    iowt_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    iowt_dec_unit u_dec (
        .i_cycles (rd_data.cycles),
        .o_dec    (dec)
    );

    assign busy     = (r_state == ST_WALK);
    assign cmd_xfer = start && !busy;
    // Read address is taken from n_idx so the registered entry at r_idx is ready in time
    assign rd_idx   = n_idx[IDX_W-1:0];

    // Sequencer and datapath control
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_kept       = r_kept;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_strobe     = 1'b0;
        n_result     = r_result;
        wr_en        = 1'b0;
        wr_idx       = r_count[IDX_W-1:0];
        wr_data.id     = i_cmd.process_id;
        wr_data.cycles = (i_cmd.duration == 8'd0) ? 8'd1 : i_cmd.duration;

        case (r_state)
            ST_IDLE: begin
                if (cmd_xfer) begin
                    n_strobe         = 1'b1;
                    n_result.done_id = 8'd0;
                    n_result.last    = 1'b1;
                    if (i_cmd.operation == OP_ADD) begin
                        if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                            n_result.kind = KIND_FULL;
                        end else begin
                            wr_en         = 1'b1;
                            n_count       = r_count + CNT_W'(1);
                            n_result.kind = KIND_ADDED;
                        end
                    end else if (r_count == '0) begin
                        n_result.kind = KIND_NONE;
                    end else begin
                        n_strobe     = 1'b0;
                        n_state      = ST_WALK;
                        n_idx        = '0;
                        n_kept       = '0;
                        n_pend_valid = 1'b0;
                    end
                end
            end
            ST_WALK: begin
                if (r_idx != r_count) begin
                    // One entry per cycle: expire or compact down to the kept slot
                    if (dec.expired) begin
                        if (r_pend_valid) begin
                            n_strobe         = 1'b1;
                            n_result.kind    = KIND_DONE;
                            n_result.done_id = r_pend_id;
                            n_result.last    = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_id    = rd_data.id;
                    end else begin
                        wr_en          = 1'b1;
                        wr_idx         = r_kept[IDX_W-1:0];
                        wr_data.id     = rd_data.id;
                        wr_data.cycles = dec.cycles;
                        n_kept         = r_kept + CNT_W'(1);
                    end
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    // Walk done: release the held completion, if any, as the last result (else a none result)
                    n_strobe      = 1'b1;
                    n_result.last = 1'b1;
                    if (r_pend_valid) begin
                        n_result.kind    = KIND_DONE;
                        n_result.done_id = r_pend_id;
                    end else begin
                        n_result.kind    = KIND_NONE;
                        n_result.done_id = 8'd0;
                    end
                    n_pend_valid = 1'b0;
                    n_count      = r_kept;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_kept       <= '0;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_kept       <= n_kept;
            r_pend_valid <= n_pend_valid;
            r_strobe     <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_id <= n_pend_id;
        r_result  <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Fill count never exceeds the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // Compaction never writes ahead of the read point
    a_kept_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_kept <= r_idx && r_idx <= r_count))
        else $error("walk pointers out of order");

    // Only completions may be followed by more results of the same command
    a_not_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> (o_result.kind == KIND_DONE))
        else $error("non-final result that is not a completion");

    // End of a walk always delivers the final result
    a_walk_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_result.last))
        else $error("walk ended without final result");

    // No result while a walk has held nothing back yet
    a_walk_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(!busy)) |-> !o_strobe)
        else $error("result at walk start");

endmodule
